// File: hw/rtl/edge_triggered_sample_capture_assert.svh
// Assertion macros used by the edge trigger capture checker.
`ifndef EDGE_TRIGGERED_SAMPLE_CAPTURE_ASSERT_SVH
`define EDGE_TRIGGERED_SAMPLE_CAPTURE_ASSERT_SVH

// Same-cycle implication, sampled on clk, held off during reset.
`define ETSC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("etsc check failed");

// Next-cycle implication, sampled on clk, held off during reset.
`define ETSC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("etsc check failed");

`endif

// File: hw/rtl/etsc_pkg.sv
// Shared types, constants and codes for the edge trigger capture block.
package etsc_pkg;

    localparam int RECORD_LENGTH = 1024;
    localparam int CNT_W         = (RECORD_LENGTH > 2) ? $clog2(RECORD_LENGTH) : 1;
    localparam int ADDR_W        = 10;
    localparam int SAMPLE_W      = 12;
    localparam int MODE_W        = 2;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 12;
    localparam int S_TDATA_W     = 16;
    localparam int M_TDATA_W     = 40;

    typedef logic [CNT_W-1:0]    cnt_t;
    typedef logic [ADDR_W-1:0]   addr_t;
    typedef logic [SAMPLE_W-1:0] sample_t;
    typedef logic [MODE_W-1:0]   mode_t;

    // trigger modes; the unused code behaves like no trigger
    localparam mode_t MODE_NONE    = 2'd0;
    localparam mode_t MODE_FALLING = 2'd1;
    localparam mode_t MODE_RISING  = 2'd2;

    // register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_LEVEL   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_LEVEL    = 2'd2;

    // item kinds
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_CLEAR  = 1'b1;

    localparam sample_t HIGH_LEVEL_RST = 12'd500;
    localparam sample_t LOW_LEVEL_RST  = 12'd50;

    localparam cnt_t LAST_SLOT = cnt_t'(RECORD_LENGTH - 1);

    typedef struct packed {
        mode_t   trigger_mode;
        sample_t high_level;
        sample_t low_level;
    } cfg_t;

    typedef struct packed {
        logic    kind;
        sample_t sample;
    } item_t;

    typedef struct packed {
        addr_t   store_address;
        sample_t store_data;
        logic    store_enable;
        logic    edge_here;
        logic    falling_seen;
        logic    rising_seen;
        addr_t   trigger_index;
        logic    capture_done;
    } result_t;

endpackage

// File: hw/rtl/etsc_cfg.sv
// Configuration register file: trigger mode, high edge level and low edge level.
module etsc_cfg
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [etsc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [etsc_pkg::CFG_DATA_W-1:0]     cfg_data,
    output etsc_pkg::cfg_t                      cfg
);

    etsc_pkg::cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.trigger_mode <= etsc_pkg::MODE_NONE;
            cfg_reg.high_level   <= etsc_pkg::HIGH_LEVEL_RST;
            cfg_reg.low_level    <= etsc_pkg::LOW_LEVEL_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                etsc_pkg::REG_TRIGGER_MODE:
                    cfg_reg.trigger_mode <= cfg_data[etsc_pkg::MODE_W-1:0];
                etsc_pkg::REG_HIGH_LEVEL:
                    cfg_reg.high_level <= cfg_data[etsc_pkg::SAMPLE_W-1:0];
                etsc_pkg::REG_LOW_LEVEL:
                    cfg_reg.low_level <= cfg_data[etsc_pkg::SAMPLE_W-1:0];
                default:
                    ;  // writes past the last register are dropped
            endcase
        end
    end

endmodule

// File: hw/rtl/etsc_in_stage.sv
// Input register stage: holds one accepted beat until the detect stage takes it.
module etsc_in_stage
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  etsc_pkg::item_t in_item,
    input  logic            advance,
    output logic            item_valid,
    output etsc_pkg::item_t item
);

    logic            valid_reg;
    etsc_pkg::item_t item_reg;

    assign in_ready   = !valid_reg || advance;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

endmodule

// File: hw/rtl/etsc_detect.sv
// Slot counter, edge detector and sticky trigger state; builds one result per item.
module etsc_detect
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  etsc_pkg::item_t   item,
    input  etsc_pkg::cfg_t    cfg,
    output etsc_pkg::result_t result
);

    etsc_pkg::sample_t prev_reg,      prev_next;
    etsc_pkg::cnt_t    slot_cnt_reg,  slot_cnt_next;
    logic              falling_reg,   falling_next;
    logic              rising_reg,    rising_next;
    etsc_pkg::cnt_t    last_slot_reg, last_slot_next;

    logic              fall_hit;
    logic              rise_hit;
    logic              edge_hit;
    logic              wrap;

    // slot zero of a record never compares, even across the wrap
    assign fall_hit = (slot_cnt_reg != '0) && (prev_reg > cfg.high_level)
                      && (item.sample < cfg.low_level);
    assign rise_hit = (slot_cnt_reg != '0) && (prev_reg < cfg.low_level)
                      && (item.sample > cfg.high_level);
    assign wrap     = (slot_cnt_reg == etsc_pkg::LAST_SLOT);

    always_comb
    begin
        prev_next      = prev_reg;
        slot_cnt_next  = slot_cnt_reg;
        falling_next   = falling_reg;
        rising_next    = rising_reg;
        last_slot_next = last_slot_reg;
        edge_hit       = 1'b0;

        if (item.kind == etsc_pkg::KIND_CLEAR)
        begin
            falling_next = 1'b0;
            rising_next  = 1'b0;
        end
        else
        begin
            case (cfg.trigger_mode)
                etsc_pkg::MODE_FALLING:
                begin
                    if (fall_hit)
                    begin
                        falling_next   = 1'b1;
                        last_slot_next = slot_cnt_reg;
                        edge_hit       = 1'b1;
                    end
                end
                etsc_pkg::MODE_RISING:
                begin
                    if (rise_hit)
                    begin
                        rising_next    = 1'b1;
                        last_slot_next = slot_cnt_reg;
                        edge_hit       = 1'b1;
                    end
                end
                default:
                    ;  // no trigger detection
            endcase
            prev_next     = item.sample;
            slot_cnt_next = wrap ? '0 : slot_cnt_reg + etsc_pkg::cnt_t'(1);
        end
    end

    always_comb
    begin
        result.store_address = etsc_pkg::addr_t'(slot_cnt_reg);
        result.store_data    = (item.kind == etsc_pkg::KIND_SAMPLE) ? item.sample : '0;
        result.store_enable  = (item.kind == etsc_pkg::KIND_SAMPLE);
        result.edge_here     = edge_hit;
        result.falling_seen  = falling_next;
        result.rising_seen   = rising_next;
        result.trigger_index = etsc_pkg::addr_t'(last_slot_next);
        result.capture_done  = (item.kind == etsc_pkg::KIND_SAMPLE) && wrap;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg      <= '0;
            slot_cnt_reg  <= '0;
            falling_reg   <= 1'b0;
            rising_reg    <= 1'b0;
            last_slot_reg <= '0;
        end
        else if (en)
        begin
            prev_reg      <= prev_next;
            slot_cnt_reg  <= slot_cnt_next;
            falling_reg   <= falling_next;
            rising_reg    <= rising_next;
            last_slot_reg <= last_slot_next;
        end
    end

endmodule

// File: hw/rtl/etsc_out_stage.sv
// Result register stage: holds one result beat until the sink takes it.
module etsc_out_stage
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  etsc_pkg::result_t in_result,
    output logic              advance,
    output logic              out_valid,
    input  logic              out_ready,
    output etsc_pkg::result_t out_result
);

    logic              valid_reg;
    etsc_pkg::result_t result_reg;

    assign advance    = !valid_reg || out_ready;
    assign out_valid  = valid_reg;
    assign out_result = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid)
        begin
            result_reg <= in_result;
        end
    end

endmodule

// File: hw/rtl/edge_triggered_sample_capture.sv
// Beats pass the input register, then the result register, on to the master side.
// Throughput: one beat per cycle while m_axis_tready is high; an input register and a
// result register form a two-stage pipeline whose ready follows the master-side tready.
// Reset (rst_n, async, active low): pipeline empty, counter, flags, trigger slot and
// previous sample zero; trigger mode none, high level 500, low level 50.
module edge_triggered_sample_capture
(
    input  logic                                clk,
    input  logic                                rst_n,

    // sample stream in
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [etsc_pkg::S_TDATA_W-1:0]      s_axis_tdata,   // [11:0] sample, [15:12] zero
    input  logic                                s_axis_tuser,   // [0] kind (1 = clear flags)

    // result stream out
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [9:0] store_address, [21:10] store_data, [22] edge_here, [23] falling_seen,
    // [24] rising_seen, [34:25] trigger_index, [39:35] zero
    output logic [etsc_pkg::M_TDATA_W-1:0]      m_axis_tdata,
    output logic                                m_axis_tuser,   // [0] store_enable
    output logic                                m_axis_tlast,   // capture_done

    // register writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [etsc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [etsc_pkg::CFG_DATA_W-1:0]     cfg_data
);

    etsc_pkg::cfg_t    cfg;
    etsc_pkg::item_t   in_item;
    etsc_pkg::item_t   item;
    logic              item_valid;
    logic              advance;
    etsc_pkg::result_t result;
    etsc_pkg::result_t out_result;

    assign in_item.kind   = s_axis_tuser;
    assign in_item.sample = s_axis_tdata[etsc_pkg::SAMPLE_W-1:0];

    etsc_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // stage 1: input register
    etsc_in_stage u_in
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_item    (in_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    // state moves only when the held beat passes into the result register
    etsc_detect u_detect
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (item_valid && advance),
        .item   (item),
        .cfg    (cfg),
        .result (result)
    );

    // stage 2: result register
    etsc_out_stage u_out
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (item_valid),
        .in_result  (result),
        .advance    (advance),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_result (out_result)
    );

    assign m_axis_tdata = {5'b0,
                           out_result.trigger_index,
                           out_result.rising_seen,
                           out_result.falling_seen,
                           out_result.edge_here,
                           out_result.store_data,
                           out_result.store_address};
    assign m_axis_tuser = out_result.store_enable;
    assign m_axis_tlast = out_result.capture_done;

endmodule

// File: hw/rtl/etsc_checker.sv
// Port-level checks for the edge trigger capture block, bound to the top level.
`include "edge_triggered_sample_capture_assert.svh"

module etsc_checker
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    input  logic [etsc_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    input  logic                            m_axis_tuser,
    input  logic                            m_axis_tlast
);

    // a stalled result beat holds
    `ETSC_ASSERT_NEXT(a_stall_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))

    // record end only on a stored sample
    `ETSC_ASSERT_NOW(a_done_on_sample, m_axis_tvalid && m_axis_tlast, m_axis_tuser)

    // an edge sets a flag and points the trigger index at its own slot
    `ETSC_ASSERT_NOW(a_edge_consistent, m_axis_tvalid && m_axis_tdata[22], m_axis_tuser && (m_axis_tdata[23] || m_axis_tdata[24]) && (m_axis_tdata[34:25] == m_axis_tdata[9:0]))

    // a clear beat shows both flags down and no data
    `ETSC_ASSERT_NOW(a_clear_beat, m_axis_tvalid && !m_axis_tuser, !m_axis_tdata[22] && !m_axis_tdata[23] && !m_axis_tdata[24] && (m_axis_tdata[21:10] == 12'd0))

endmodule

bind edge_triggered_sample_capture etsc_checker u_etsc_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

// File: verif/tb_edge_triggered_sample_capture.sv
// Self-checking testbench for edge_triggered_sample_capture: directed edges, random streams.
module tb_edge_triggered_sample_capture;

    localparam int SEGMENT_ITEMS = 138;
    localparam int STALL_CYCLES  = 400;
    localparam int SETTLE_CYCLES = 4;
    localparam int MAX_REPORTS   = 10;

    // Tracks the block state and holds the captures still due on the master side.
    class capture_checker;
        etsc_pkg::result_t awaited[$];
        int unsigned       mismatches;
        etsc_pkg::mode_t   mode;
        etsc_pkg::sample_t high_lvl;
        etsc_pkg::sample_t low_lvl;
        etsc_pkg::sample_t prev_smp;
        int unsigned       slot;
        logic              fall_flag;
        logic              rise_flag;
        int unsigned       trig_slot;

        function new();
            mode       = etsc_pkg::MODE_NONE;
            high_lvl   = etsc_pkg::HIGH_LEVEL_RST;
            low_lvl    = etsc_pkg::LOW_LEVEL_RST;
            prev_smp   = '0;
            slot       = 0;
            fall_flag  = 1'b0;
            rise_flag  = 1'b0;
            trig_slot  = 0;
            mismatches = 0;
        endfunction

        function void note_register(logic [etsc_pkg::CFG_IDX_W-1:0] idx,
                                    logic [etsc_pkg::CFG_DATA_W-1:0] data);
            if (idx == etsc_pkg::REG_TRIGGER_MODE)
                mode = data[etsc_pkg::MODE_W-1:0];
            else if (idx == etsc_pkg::REG_HIGH_LEVEL)
                high_lvl = data;
            else if (idx == etsc_pkg::REG_LOW_LEVEL)
                low_lvl = data;
        endfunction

        // Works out the capture caused by one accepted input beat.
        function void note_sample_beat(etsc_pkg::item_t it);
            etsc_pkg::result_t r;
            r = '0;
            r.store_address = etsc_pkg::addr_t'(slot);
            if (it.kind == etsc_pkg::KIND_CLEAR) begin
                fall_flag = 1'b0;
                rise_flag = 1'b0;
            end
            else begin
                r.store_enable = 1'b1;
                r.store_data   = it.sample;
                // first slot of a record never compares, even across the wrap
                if (slot >= 1) begin
                    if (mode == etsc_pkg::MODE_FALLING) begin
                        if (prev_smp > high_lvl && it.sample < low_lvl) begin
                            fall_flag   = 1'b1;
                            trig_slot   = slot;
                            r.edge_here = 1'b1;
                        end
                    end
                    else if (mode == etsc_pkg::MODE_RISING) begin
                        if (prev_smp < low_lvl && it.sample > high_lvl) begin
                            rise_flag   = 1'b1;
                            trig_slot   = slot;
                            r.edge_here = 1'b1;
                        end
                    end
                end
                prev_smp = it.sample;
                slot++;
                if (slot >= etsc_pkg::RECORD_LENGTH) begin
                    slot           = 0;
                    r.capture_done = 1'b1;
                end
            end
            r.falling_seen  = fall_flag;
            r.rising_seen   = rise_flag;
            r.trigger_index = etsc_pkg::addr_t'(trig_slot);
            awaited.push_back(r);
        endfunction

        function string show(etsc_pkg::result_t r);
            return $sformatf("addr=%0d data=%0d en=%0b edge=%0b fall=%0b rise=%0b trig=%0d done=%0b",
                             r.store_address, r.store_data, r.store_enable, r.edge_here,
                             r.falling_seen, r.rising_seen, r.trigger_index, r.capture_done);
        endfunction

        function void check_capture_beat(etsc_pkg::result_t got);
            etsc_pkg::result_t want;
            string             bad;
            if (awaited.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected capture beat: %s", show(got));
                return;
            end
            want = awaited.pop_front();
            bad  = "";
            if (got.store_address != want.store_address) bad = {bad, " store_address"};
            if (got.store_data    != want.store_data)    bad = {bad, " store_data"};
            if (got.store_enable  != want.store_enable)  bad = {bad, " store_enable"};
            if (got.edge_here     != want.edge_here)     bad = {bad, " edge_here"};
            if (got.falling_seen  != want.falling_seen)  bad = {bad, " falling_seen"};
            if (got.rising_seen   != want.rising_seen)   bad = {bad, " rising_seen"};
            if (got.trigger_index != want.trigger_index) bad = {bad, " trigger_index"};
            if (got.capture_done  != want.capture_done)  bad = {bad, " capture_done"};
            if (bad != "") begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("capture mismatch at %0t (%s)\n  expected %s\n  actual   %s",
                             $realtime, bad, show(want), show(got));
            end
        endfunction

        function int unsigned outstanding();
            return awaited.size();
        endfunction

        function int unsigned problems();
            return mismatches + awaited.size();
        endfunction
    endclass

    logic                                  clk = 1'b0;
    logic                                  rst_n = 1'b0;
    logic                                  s_axis_tvalid = 1'b0;
    logic                                  s_axis_tready;
    logic [etsc_pkg::S_TDATA_W-1:0]        s_axis_tdata = '0;
    logic                                  s_axis_tuser = 1'b0;
    logic                                  m_axis_tvalid;
    logic                                  m_axis_tready = 1'b0;
    logic [etsc_pkg::M_TDATA_W-1:0]        m_axis_tdata;
    logic                                  m_axis_tuser;
    logic                                  m_axis_tlast;
    logic                                  cfg_valid = 1'b0;
    logic                                  cfg_ready;
    logic [etsc_pkg::CFG_IDX_W-1:0]        cfg_index = '0;
    logic [etsc_pkg::CFG_DATA_W-1:0]       cfg_data = '0;

    capture_checker sb;

    // idle rates in percent, set per phase
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;

    // long receiver hold-off: bump stall_arm, the sink counts it down
    int unsigned stall_arm = 0;
    int unsigned stall_taken = 0;
    int unsigned stall_left = 0;

    // generator view: level settings and slot of the next generated sample
    int          cur_high = etsc_pkg::HIGH_LEVEL_RST;
    int          cur_low  = etsc_pkg::LOW_LEVEL_RST;
    int unsigned gen_slot = 0;
    int unsigned gen_samples = 0;

    edge_triggered_sample_capture dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    initial
    begin
        #800000;
        $display("RESULT: ERROR");
        $finish;
    end

    // Result sink: checks accepted beats, then decides tready for the next cycle.
    always @(posedge clk)
    begin : capture_sink
        etsc_pkg::result_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            got.store_address = m_axis_tdata[9:0];
            got.store_data    = m_axis_tdata[21:10];
            got.edge_here     = m_axis_tdata[22];
            got.falling_seen  = m_axis_tdata[23];
            got.rising_seen   = m_axis_tdata[24];
            got.trigger_index = m_axis_tdata[34:25];
            got.store_enable  = m_axis_tuser;
            got.capture_done  = m_axis_tlast;
            sb.check_capture_beat(got);
        end
        if (stall_arm != stall_taken) begin
            stall_taken = stall_arm;
            stall_left  = STALL_CYCLES;
        end
        if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end
        else begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic etsc_pkg::item_t smp(etsc_pkg::sample_t v);
        return etsc_pkg::item_t'{kind: etsc_pkg::KIND_SAMPLE, sample: v};
    endfunction

    function automatic etsc_pkg::item_t clr(etsc_pkg::sample_t v);
        return etsc_pkg::item_t'{kind: etsc_pkg::KIND_CLEAR, sample: v};
    endfunction

    // Random item: mostly samples around the levels and the rails so edges show up.
    function automatic etsc_pkg::item_t next_item();
        int              v;
        etsc_pkg::item_t it;
        if ($urandom_range(99) < 8)
            return clr(etsc_pkg::sample_t'($urandom));
        case ($urandom_range(9))
            0: v = 0;
            1: v = 4095;
            2: v = (cur_high < 4095) ? cur_high + 1 : 4095;
            3: v = cur_high;
            4: v = (cur_low > 0) ? cur_low - 1 : 0;
            5: v = cur_low;
            6: v = (cur_high < 4095) ? $urandom_range(4095, cur_high + 1) : 4095;
            7: v = (cur_low > 0) ? $urandom_range(cur_low - 1, 0) : 0;
            default: v = $urandom_range(4095);
        endcase
        // straddle the record wrap with a falling pattern; no edge may appear there
        if (gen_slot == etsc_pkg::RECORD_LENGTH - 1)
            v = 4095;
        else if (gen_slot == 0 && gen_samples > 0)
            v = 0;
        gen_samples++;
        gen_slot = (gen_slot + 1) % etsc_pkg::RECORD_LENGTH;
        it = smp(etsc_pkg::sample_t'(v));
        return it;
    endfunction

    // Called right after a rising edge; returns at the edge where the beat is taken.
    task automatic send_item(etsc_pkg::item_t it);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct && gap < 40)
            gap++;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.kind;
        s_axis_tdata  <= {{(etsc_pkg::S_TDATA_W-etsc_pkg::SAMPLE_W){1'b0}}, it.sample};
        do @(posedge clk); while (!s_axis_tready);
        sb.note_sample_beat(it);
    endtask

    // Wait for every capture to come back, then let the pipeline settle.
    task automatic drain_pipeline();
        s_axis_tvalid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [etsc_pkg::CFG_IDX_W-1:0] idx,
                             logic [etsc_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        sb.note_register(idx, data);
    endtask

    task automatic configure(logic [etsc_pkg::CFG_DATA_W-1:0] mode_word,
                             etsc_pkg::sample_t hi, etsc_pkg::sample_t lo);
        write_reg(etsc_pkg::REG_TRIGGER_MODE, mode_word);
        write_reg(etsc_pkg::REG_HIGH_LEVEL, hi);
        write_reg(etsc_pkg::REG_LOW_LEVEL, lo);
        cfg_valid <= 1'b0;
        cur_high = hi;
        cur_low  = lo;
    endtask

    task automatic send_directed(etsc_pkg::item_t it);
        if (it.kind == etsc_pkg::KIND_SAMPLE) begin
            gen_samples++;
            gen_slot = (gen_slot + 1) % etsc_pkg::RECORD_LENGTH;
        end
        send_item(it);
    endtask

    initial
    begin
        logic [etsc_pkg::CFG_DATA_W-1:0] seg_mode [6];
        etsc_pkg::sample_t               seg_high [6];
        etsc_pkg::sample_t               seg_low  [6];

        sb = new();
        // phase settings: moderate levels first, then the rails, then equal levels
        seg_mode = '{etsc_pkg::CFG_DATA_W'(etsc_pkg::MODE_FALLING),
                     etsc_pkg::CFG_DATA_W'(etsc_pkg::MODE_RISING), 12'd3,
                     etsc_pkg::CFG_DATA_W'(etsc_pkg::MODE_RISING),
                     etsc_pkg::CFG_DATA_W'(etsc_pkg::MODE_FALLING),
                     etsc_pkg::CFG_DATA_W'(etsc_pkg::MODE_FALLING)};
        seg_high = '{12'd2000, 12'd3000, 12'd0, 12'd0, 12'd4095, 12'd1500};
        seg_low  = '{12'd1000, 12'd800, 12'd4095, 12'd4095, 12'd0, 12'd1500};

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // rising edges at reset levels; the very first slot must not compare
        configure(etsc_pkg::CFG_DATA_W'(etsc_pkg::MODE_RISING),
                  etsc_pkg::HIGH_LEVEL_RST, etsc_pkg::LOW_LEVEL_RST);
        send_directed(smp(12'd4095));
        send_directed(smp(12'd0));
        send_directed(smp(12'd4095));
        send_directed(smp(12'd49));
        send_directed(smp(12'd501));
        send_directed(smp(12'd50));
        send_directed(smp(12'd501));
        send_directed(smp(12'd49));
        send_directed(smp(12'd500));
        send_directed(clr(12'hABC));
        send_directed(smp(12'd0));
        drain_pipeline();

        // falling edges, boundaries just on and off the levels
        configure(etsc_pkg::CFG_DATA_W'(etsc_pkg::MODE_FALLING),
                  etsc_pkg::HIGH_LEVEL_RST, etsc_pkg::LOW_LEVEL_RST);
        send_directed(smp(12'd501));
        send_directed(smp(12'd49));
        send_directed(smp(12'd500));
        send_directed(smp(12'd49));
        send_directed(smp(12'd501));
        send_directed(smp(12'd50));
        send_directed(smp(12'd4095));
        send_directed(smp(12'd0));
        send_directed(clr(12'h543));
        drain_pipeline();

        // unused mode code, upper write bits set: acts like no trigger
        configure(12'hFFF, etsc_pkg::HIGH_LEVEL_RST, etsc_pkg::LOW_LEVEL_RST);
        send_directed(smp(12'd0));
        send_directed(smp(12'd4095));
        drain_pipeline();

        configure(etsc_pkg::CFG_DATA_W'(etsc_pkg::MODE_NONE),
                  etsc_pkg::HIGH_LEVEL_RST, etsc_pkg::LOW_LEVEL_RST);
        send_directed(smp(12'd4095));
        send_directed(smp(12'd0));
        drain_pipeline();

        // random phases; sender pauses for a full drain before each register update
        for (int seg = 0; seg < 6; seg++) begin
            configure(seg_mode[seg], seg_high[seg], seg_low[seg]);
            if (seg < 2) begin
                send_idle_pct = 11;
                recv_idle_pct = 75;
            end
            else if (seg < 4) begin
                send_idle_pct = 75;
                recv_idle_pct = 11;
            end
            else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            // block the sink while the source runs flat out so input backs up
            if (seg == 4)
                stall_arm++;
            repeat (SEGMENT_ITEMS) send_item(next_item());
            drain_pipeline();
        end

        if (sb.problems() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
